// ===== hdl/fpa_pkg.sv =====
package fpa_pkg;

  localparam int unsigned DivSteps = 32;

  localparam logic [32:0] QOne      = 33'h1_0000_0000;
  localparam logic [31:0] CoefCube  = 32'h3123_8038;
  localparam logic [31:0] CoefLin   = 32'hF8EE_D205;
  localparam logic [35:0] OfsQuart  = 36'h0_C90F_DAA2;
  localparam logic [35:0] Ofs3Quart = 36'h2_5B2F_8FE6;

  typedef struct packed {
    logic signed [63:0] y_coord;
    logic signed [63:0] x_coord;
  } in_data_t;

  typedef struct packed {
    logic signed [34:0] angle;
    logic               zero_vector;
  } out_data_t;

  typedef struct packed {
    logic zero;
    logic yneg;
    logic nneg;
    logic nzero;
    logic sat;
    logic ofs_sel;
  } side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] den;
    logic [31:0] q;
    side_t       side;
  } div_t;

  // Q0.64 product rounded to Q1.32: half up, or half toward zero for negative results.
  function automatic logic [32:0] qrnd(input logic [63:0] p, input logic neg);
    logic [64:0] s;
    s = {1'b0, p} + (neg ? 65'h7FFF_FFFF : 65'h8000_0000);
    return s[64:32];
  endfunction

endpackage

// ===== hdl/fixed_point_atan2_approx.sv =====
// Pipeline: 1 front register, 32 divider cells and 4 poly stages between input transaction and result.
// Throughput: one transaction per cycle while the pipeline advances; a 32-cell restoring
// divider chain, one quotient bit per cell, followed by the 32x32 multiply stages sets the depth.
// The whole pipeline advances when the output register is empty or taken.
// Reset (rst_n low, synchronous) clears all valid flags; no results pending.
module fixed_point_atan2_approx
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_data_t out_data
);

  logic                  adv;
  logic                  yneg, xneg;
  logic [63:0]           ym, xm, nmag, den;
  logic                  nneg;
  side_t                 side;
  div_t                  front_nxt;
  logic                  front_vld_r;
  div_t                  front_r;
  logic [DivSteps:0]     vld;
  div_t [DivSteps:0]     stg;
  logic [32:0]           rm;
  div_t                  last;

  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  always_comb begin
    yneg = in_data.y_coord[63];
    xneg = in_data.x_coord[63];
    ym   = yneg ? (64'd0 - in_data.y_coord) : in_data.y_coord;
    xm   = xneg ? (64'd0 - in_data.x_coord) : in_data.x_coord;
    den  = xm + ym;
    if (!xneg) begin
      nneg = xm < ym;
      nmag = nneg ? (ym - xm) : (xm - ym);
    end else begin
      nneg = ym < xm;
      nmag = nneg ? (xm - ym) : (ym - xm);
    end
    side.zero    = (in_data.x_coord == 64'sd0) && (in_data.y_coord == 64'sd0);
    side.yneg    = yneg;
    side.nneg    = nneg;
    side.nzero   = (nmag == 64'd0);
    side.sat     = (nmag >= den);
    side.ofs_sel = xneg;
    front_nxt.rem  = nmag;
    front_nxt.den  = den;
    front_nxt.q    = '0;
    front_nxt.side = side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= 1'b0;
    end else if (adv) begin
      front_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front_r <= front_nxt;
    end
  end

  assign vld[0] = front_vld_r;
  assign stg[0] = front_r;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    fpa_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .vld_in  (vld[i]),
      .d_in    (stg[i]),
      .vld_out (vld[i+1]),
      .d_out   (stg[i+1])
    );
  end

  assign last = stg[DivSteps];

  always_comb begin
    if (last.side.nzero || last.side.zero) begin
      rm = 33'd0;
    end else if (last.side.sat) begin
      rm = QOne;
    end else begin
      rm = {1'b0, last.q};
    end
  end

  fpa_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .vld_in   (vld[DivSteps]),
    .rm_in    (rm),
    .side_in  (last.side),
    .vld_out  (out_valid),
    .data_out (out_data)
  );

  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_vector) |-> (out_data.angle == 35'sd0))
    else $error("zero vector with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.angle <= 35'sd13500000000) &&
                   (out_data.angle >= -35'sd13500000000)))
    else $error("angle out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken during output stall");

endmodule

// ===== hdl/fpa_div_cell.sv =====
module fpa_div_cell
  import fpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic vld_in,
  input  div_t d_in,
  output logic vld_out,
  output div_t d_out
);

  logic        vld_r;
  div_t        d_r;
  logic [63:0] sh;
  logic        take;
  div_t        d_nxt;

  always_comb begin
    sh         = {d_in.rem[62:0], 1'b0};
    take       = d_in.rem[63] || (sh >= d_in.den);
    d_nxt      = d_in;
    d_nxt.rem  = take ? (sh - d_in.den) : sh;
    d_nxt.q    = {d_in.q[30:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

  // remainder stays below divisor on the true division path
  a_rem_lt_den: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !d_r.side.sat && !d_r.side.nzero && !d_r.side.zero) |-> (d_r.rem < d_r.den))
    else $error("remainder not below divisor");

endmodule

// ===== hdl/fpa_poly.sv =====
module fpa_poly
  import fpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        vld_in,
  input  logic [32:0] rm_in,
  input  side_t       side_in,
  output logic        vld_out,
  output out_data_t   data_out
);

  logic [3:0]  vld_r;
  logic [32:0] rm1_r, rm2_r;
  logic [32:0] r2m_r, r2m_nxt;
  logic        rneg1_r, rneg2_r, rneg_in;
  side_t       s1_r, s2_r, s3_r;
  logic [32:0] r3m_r, r3m_nxt;
  logic        r3neg_r;
  logic signed [35:0] c1_nxt, c1a_r, c1b_r;
  logic [32:0] c1m;
  logic [32:0] c3m;
  logic signed [35:0] c3_nxt, c3_r;
  logic signed [35:0] sum, ang;
  out_data_t   out_nxt, out_r;

  assign rneg_in = side_in.nneg && (rm_in != 33'd0);

  always_comb begin
    r2m_nxt = (rm_in == QOne) ? QOne : qrnd(rm_in[31:0] * rm_in[31:0], 1'b0);

    if (r2m_r == QOne) begin
      r3m_nxt = rm1_r;
    end else if (rm1_r == QOne) begin
      r3m_nxt = r2m_r;
    end else begin
      r3m_nxt = qrnd(r2m_r[31:0] * rm1_r[31:0], rneg1_r);
    end
    c1m    = (rm1_r == QOne) ? {1'b0, CoefLin} : qrnd(CoefLin * rm1_r[31:0], rneg1_r);
    c1_nxt = rneg1_r ? -$signed({3'b0, c1m}) : $signed({3'b0, c1m});

    c3m    = (r3m_r == QOne) ? {1'b0, CoefCube} : qrnd(CoefCube * r3m_r[31:0], r3neg_r);
    c3_nxt = r3neg_r ? -$signed({3'b0, c3m}) : $signed({3'b0, c3m});

    sum = c3_r - c1b_r + $signed(s3_r.ofs_sel ? Ofs3Quart : OfsQuart);
    ang = s3_r.yneg ? -sum : sum;
    out_nxt.angle       = s3_r.zero ? 35'sd0 : ang[34:0];
    out_nxt.zero_vector = s3_r.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rm1_r   <= rm_in;
      r2m_r   <= r2m_nxt;
      rneg1_r <= rneg_in;
      s1_r    <= side_in;
      r3m_r   <= r3m_nxt;
      r3neg_r <= rneg1_r && (r3m_nxt != 33'd0);
      c1a_r   <= c1_nxt;
      rm2_r   <= rm1_r;
      rneg2_r <= rneg1_r;
      s2_r    <= s1_r;
      c3_r    <= c3_nxt;
      c1b_r   <= c1a_r;
      s3_r    <= s2_r;
      out_r   <= out_nxt;
    end
  end

  assign vld_out  = vld_r[3];
  assign data_out = out_r;

  // a negative cube term comes only from a negative ratio
  a_r3_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && r3neg_r) |-> rneg2_r)
    else $error("cube sign without negative ratio");

  a_rm_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (rm2_r <= QOne))
    else $error("ratio above one");

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import fpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeDepth = 37;
  localparam int unsigned RandItems = 1500;

  localparam logic [63:0] QuarterPi   = 64'h0000_0000_C90F_DAA2;
  localparam logic [63:0] ThreeQtrPi  = 64'h0000_0002_5B2F_8FE6;
  localparam logic [63:0] CubeCoef    = 64'h0000_0000_3123_8038;
  localparam logic [63:0] LinCoef     = 64'h0000_0000_F8EE_D205;
  localparam logic [63:0] UnitQ       = 64'h0000_0001_0000_0000;
  localparam logic [63:0] MinVal      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal      = 64'h7FFF_FFFF_FFFF_FFFF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_data_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_data_t out_data;

  out_data_t angle_q[$];
  int        errors;
  bit        stall_enable;

  fixed_point_atan2_approx uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Truncating ratio n/d in Q32.32, saturating at one.
  function automatic logic [63:0] div_ratio(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    if (n >= d) return UnitQ;
    rem = {1'b0, n};
    q = '0;
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] mul_q(logic signed [63:0] a, logic signed [63:0] b);
    logic        neg;
    logic [63:0] ma, mb, m;
    logic [127:0] p;
    neg = a[63] ^ b[63];
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    if (ma > UnitQ) ma = UnitQ;
    if (mb > UnitQ) mb = UnitQ;
    if (ma == UnitQ) m = mb;
    else if (mb == UnitQ) m = ma;
    else begin
      p = ma * mb;
      p = p + (neg ? 128'h7FFF_FFFF : 128'h8000_0000);
      m = p[95:32];
    end
    return neg ? -m : m;
  endfunction

  function automatic out_data_t predict_angle(in_data_t v);
    out_data_t          res;
    logic [63:0]        ym, xm, nmag, den, ofs;
    logic               nneg;
    logic signed [63:0] r, r3, ang;
    res = '0;
    if (v.x_coord == 0 && v.y_coord == 0) begin
      res.zero_vector = 1'b1;
      return res;
    end
    ym = v.y_coord[63] ? -v.y_coord : v.y_coord;
    xm = v.x_coord[63] ? -v.x_coord : v.x_coord;
    if (!v.x_coord[63]) begin
      nneg = xm < ym;
      nmag = nneg ? ym - xm : xm - ym;
      ofs = QuarterPi;
    end else begin
      nneg = ym < xm;
      nmag = nneg ? xm - ym : ym - xm;
      ofs = ThreeQtrPi;
    end
    den = xm + ym;
    if (nmag == 0) r = 0;
    else begin
      r = div_ratio(nmag, den);
      if (nneg) r = -r;
    end
    r3 = mul_q(mul_q(r, r), r);
    ang = mul_q(CubeCoef, r3) - mul_q(LinCoef, r) + ofs;
    if (v.y_coord[63]) ang = -ang;
    res.angle = ang[34:0];
    return res;
  endfunction

  task automatic send_vector(logic [63:0] y, logic [63:0] x);
    in_data_t v;
    v.y_coord = y;
    v.x_coord = x;
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    angle_q.push_back(predict_angle(v));
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [63:0] vals[8];
    vals = '{64'd0, 64'd1, MaxVal, MinVal, UnitQ, -UnitQ, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3};
    send_vector(0, 0);
    send_vector(MinVal, MinVal);
    send_vector(MaxVal, MaxVal);
    send_vector(MinVal, 0);
    send_vector(0, MinVal);
    send_vector(UnitQ, UnitQ);
    send_vector(UnitQ, -UnitQ);
    send_vector(-UnitQ, UnitQ);
    send_vector(-UnitQ, -UnitQ);
    send_vector(0, UnitQ);
    send_vector(0, -UnitQ);
    send_vector(UnitQ, 0);
    send_vector(-UnitQ, 0);
    for (int i = 0; i < 12; i++) send_vector(vals[$urandom_range(0, 7)], vals[$urandom_range(0, 7)]);
    drain_results();
  endtask

  function automatic logic [63:0] rand_coord();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = -(v >> $urandom_range(0, 63));
      2: v = (v >> 40) | (v[0] ? MinVal : 64'd0);
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_random();
    logic [63:0] y, x;
    int sent;
    sent = 0;
    while (sent < RandItems) begin
      repeat ($urandom_range(1, 40)) begin
        y = rand_coord();
        // Near-diagonal and axis vectors hit the ratio extremes.
        case ($urandom_range(0, 7))
          0: x = y;
          1: x = -y;
          2: x = 0;
          3: x = y + $urandom_range(0, 3) - 1;
          default: x = rand_coord();
        endcase
        if ($urandom_range(0, 15) == 0) y = 0;
        send_vector(y, x);
        sent++;
        if (sent == RandItems / 2) drain_results();
      end
      if ($urandom_range(0, 2) != 0) idle_sender();
    end
    drain_results();
  endtask

  // Stall the result side in alternating windows.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!stall_enable) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    stall_enable = 1'b0;
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk);
      stall_enable = ~stall_enable;
    end
  end

  always @(posedge clk) begin
    out_data_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual angle=%h zero=%b",
                 $time, out_data.angle, out_data.zero_vector);
        errors++;
      end else begin
        exp_res = angle_q.pop_front();
        if (exp_res.angle !== out_data.angle) begin
          $display("%0t: angle mismatch, expected %h actual %h",
                   $time, exp_res.angle, out_data.angle);
          errors++;
        end
        if (exp_res.zero_vector !== out_data.zero_vector) begin
          $display("%0t: zero_vector mismatch, expected %b actual %b",
                   $time, exp_res.zero_vector, out_data.zero_vector);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("fixed_point_atan2_approx test failed");
    $finish;
  end

  initial begin
    errors = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    repeat (PipeDepth + 10) @(posedge clk);
    if (errors == 0 && angle_q.size() == 0) begin
      $display("fixed_point_atan2_approx test passed");
    end else begin
      $display("fixed_point_atan2_approx test failed");
    end
    $finish;
  end

endmodule
